/* rtl/core/adcse_pkg.sv */
// Shared types and constants for the ADC smoothing and transient envelope block.
// No dependencies.
package adcse_pkg;

  typedef struct packed {
    logic [2:0] channel;
    logic [9:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         channel_out;
    logic [9:0]         average;
    logic [10:0]        scaled;
    logic signed [11:0] deviation;
    logic               transient;
    logic               band_pair;
    logic [9:0]         envelope_first;
    logic [9:0]         envelope_second;
  } out_item_t;

  localparam logic [2:0] REG_ATTEN  = 3'd0;
  localparam logic [2:0] REG_THRESH = 3'd1;
  localparam logic [2:0] REG_WIN0   = 3'd2;
  localparam logic [2:0] REG_WIN1   = 3'd3;
  localparam logic [2:0] REG_WIN2   = 3'd4;
  localparam logic [2:0] REG_WIN3   = 3'd5;

  localparam logic [10:0] GAIN_MODE0 = 11'd2047;
  localparam logic [10:0] GAIN_MODE1 = 11'd1551;
  localparam logic [10:0] GAIN_MODE2 = 11'd1023;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input, ring update, front results
    logic push;      // update sum/store of the current band
    logic div_start; // start divider for current band
    logic div_step;  // one quotient bit
    logic div_done;  // write envelope of current band
    logic next_band; // move to second band of pair
    logic finish;    // build output item
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic transient;
    logic div_last;
  } sts_t;

endpackage

/* rtl/core/adcse_ctrl.sv */
// Sequencer for the ADC smoothing block: handshakes and datapath commands.
// Depends on adcse_pkg.
module adcse_ctrl import adcse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_PUSH  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_NEXT  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    ctl_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          second_d   = 1'b0;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = sts_i.transient ? S_PUSH : S_FIN;
      end
      S_PUSH: begin
        ctl_o.push      = 1'b1;
        ctl_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          ctl_o.div_done = 1'b1;
          state_d        = S_NEXT;
        end
      end
      S_NEXT: begin
        if (second_q) begin
          state_d = S_FIN;
        end else begin
          ctl_o.next_band = 1'b1;
          second_d        = 1'b1;
          state_d         = S_PUSH;
        end
      end
      S_FIN: begin
        ctl_o.finish = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

/* rtl/core/adcse_dpath.sv */
// Datapath: sample rings, deviation, band windows and serial envelope divider,
// plus the generic registered-read RAM that holds the band stores. Depends on adcse_pkg.
module adcse_dpath import adcse_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_WINDOW   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  in_item_t   in_i,
  input  ctl_t       ctl_i,
  output sts_t       sts_o,
  output out_item_t  out_o
);

  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW  = 10 + WW;
  localparam int CW  = $clog2(SW + 1);
  localparam int CHW = (NUM_CHANNELS > 8) ? $clog2(NUM_CHANNELS) : 3;
  localparam int SD  = 4 * (2 ** IW);
  localparam int AW  = 2 + IW;

  logic [1:0]  atten_q;
  logic [10:0] thresh_q;
  logic [5:0]  win_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atten_q  <= '0;
      thresh_q <= 11'd160;
      for (int b = 0; b < 4; b++) win_q[b] <= 6'd32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTEN:  atten_q  <= cfg_data_i[1:0];
        REG_THRESH: thresh_q <= cfg_data_i;
        REG_WIN0:   win_q[0] <= cfg_data_i[5:0];
        REG_WIN1:   win_q[1] <= cfg_data_i[5:0];
        REG_WIN2:   win_q[2] <= cfg_data_i[5:0];
        REG_WIN3:   win_q[3] <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // ring: NUM_CHANNELS x 4 slots, read one channel at a time
  logic [9:0] ring_q [NUM_CHANNELS][4];
  logic [1:0] slot_q;
  logic       in_range;
  logic [CHW-1:0] ch_ext;
  logic [9:0] r [4];
  logic [11:0] sum4;
  logic [9:0]  avg;
  logic [10:0] gain;
  logic [20:0] prod;
  logic signed [12:0] dev;
  logic [11:0] mag;

  assign ch_ext   = CHW'(in_i.channel);
  assign in_range = (32'(in_i.channel) < NUM_CHANNELS);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r[k] = in_range ? ring_q[ch_ext][k] : 10'd0;
      if (2'(k) == slot_q) r[k] = in_i.sample;
    end
    sum4 = 12'(r[0]) + 12'(r[1]) + 12'(r[2]) + 12'(r[3]);
    avg  = sum4[11:2];
    case (atten_q)
      2'd0:    gain = GAIN_MODE0;
      2'd1:    gain = GAIN_MODE1;
      default: gain = GAIN_MODE2;
    endcase
    prod = 21'(avg) * 21'(gain);
    dev  = 13'(r[slot_q]) - 13'(r[slot_q - 2'd1]) + 13'(r[slot_q - 2'd2])
         - 13'(r[slot_q - 2'd3]);
    mag  = dev[12] ? 12'(-dev) : 12'(dev);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++)
        for (int k = 0; k < 4; k++) ring_q[c][k] <= '0;
    end else if (ctl_i.load && in_range) begin
      ring_q[ch_ext][slot_q] <= in_i.sample;
      if (32'(in_i.channel) == NUM_CHANNELS - 1) slot_q <= slot_q + 2'd1;
    end
  end

  // captured front results
  logic [2:0]  ch_q;
  logic [9:0]  smp_q, avg_q;
  logic [10:0] scl_q;
  logic [11:0] dev_q;
  logic        trans_q, pair_q, low_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ch_q    <= in_i.channel;
      smp_q   <= in_i.sample;
      low_q   <= in_range && (in_i.channel < 3'd4);
      avg_q   <= in_range ? avg : 10'd0;
      scl_q   <= in_range ? prod[20:10] : 11'd0;
      dev_q   <= dev[11:0];
      trans_q <= (mag > 12'(thresh_q));
      pair_q  <= in_i.channel[0];
    end
  end

  assign sts_o.transient = low_q && trans_q;

  // band windows: one store addressed {band, index}; entries at or above a band's
  // fill mark were never written since reset and count as zero
  logic [SW-1:0] bsum_q [4];
  logic [IW-1:0] bidx_q [4];
  logic [WW-1:0] fill_q [4];
  logic [9:0]    env_q [4];
  logic          bsel_q;
  logic [1:0]    band;
  logic [1:0]    rd_band;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [9:0]    old_raw, old;
  logic [WW-1:0] weff;
  logic [IW-1:0] idx;
  logic [SW-1:0] nsum;

  assign band    = {pair_q, bsel_q};
  // the read is issued the cycle before the push of that band, so the registered data is ready for it
  assign rd_band = ctl_i.next_band ? {pair_q, 1'b1} : band;
  assign rd_addr = {rd_band, bidx_q[rd_band]};
  assign wr_addr = {band, idx};

  adcse_ram #(.WIDTH(10), .DEPTH(SD)) u_store (
    .clk_i,
    .we_i(ctl_i.push),
    .waddr_i(wr_addr),
    .wdata_i(smp_q),
    .raddr_i(rd_addr),
    .rdata_o(old_raw)
  );

  always_comb begin
    if (win_q[band] == 6'd0) weff = WW'(1);
    else if (32'(win_q[band]) > MAX_WINDOW) weff = WW'(MAX_WINDOW);
    else weff = WW'(win_q[band]);
    idx  = bidx_q[band];
    old  = (32'(idx) < 32'(fill_q[band])) ? old_raw : 10'd0;
    nsum = bsum_q[band] - SW'(old) + SW'(smp_q);
  end

  // restoring divider: bsum / weff
  logic [SW-1:0] rem_q, quo_q;
  logic [WW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic [SW:0]   trial;
  logic [SW-1:0] quo_n;

  assign trial = {rem_q, quo_q[SW-1]} - (SW+1)'(div_q);
  assign quo_n = {quo_q[SW-2:0], ~trial[SW]};
  assign sts_o.div_last = (cnt_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsel_q <= 1'b0;
      for (int b = 0; b < 4; b++) begin
        bsum_q[b] <= '0;
        bidx_q[b] <= '0;
        fill_q[b] <= '0;
        env_q[b]  <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (ctl_i.load) bsel_q <= 1'b0;
      if (ctl_i.next_band) bsel_q <= 1'b1;
      if (ctl_i.push) begin
        bsum_q[band] <= nsum;
        bidx_q[band] <= (32'(idx) + 1 >= 32'(weff)) ? '0 : IW'(32'(idx) + 1);
        if (32'(idx) >= 32'(fill_q[band])) fill_q[band] <= WW'(32'(idx) + 1);
      end
      if (ctl_i.div_start) cnt_q <= CW'(SW);
      else if (ctl_i.div_step) cnt_q <= cnt_q - CW'(1);
      if (ctl_i.div_done)
        env_q[band] <= (quo_n > SW'(1023)) ? 10'd1023 : quo_n[9:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      rem_q <= '0;
      quo_q <= nsum;
      div_q <= weff;
    end else if (ctl_i.div_step) begin
      rem_q <= trial[SW] ? {rem_q[SW-2:0], quo_q[SW-1]} : trial[SW-1:0];
      quo_q <= quo_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      out_o.channel_out     <= ch_q;
      out_o.average         <= avg_q;
      out_o.scaled          <= scl_q;
      out_o.deviation       <= low_q ? dev_q : 12'd0;
      out_o.transient       <= low_q && trans_q;
      out_o.band_pair       <= low_q && pair_q;
      out_o.envelope_first  <= low_q ? env_q[{pair_q, 1'b0}] : 10'd0;
      out_o.envelope_second <= low_q ? env_q[{pair_q, 1'b1}] : 10'd0;
    end
  end

endmodule

// Generic RAM: one write port, one read port with registered read data.
module adcse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/adc_smoothing_transient_envelope.sv */
// Top level of the ADC smoothing and transient envelope block.
// Depends on adcse_pkg, adcse_ctrl and adcse_dpath.
// One sample at a time: a plain sample goes through the evaluate, finish and output
// states; a transient sample also runs, for each band of its pair, a push and the
// bit-serial divider of width SW = 10 + clog2(MAX_WINDOW+1) before finishing.
// The next sample is taken the cycle after the result transfer.
module adc_smoothing_transient_envelope import adcse_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_WINDOW   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  ctl_t ctl;
  sts_t sts;

  adcse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  adcse_dpath #(.NUM_CHANNELS(NUM_CHANNELS), .MAX_WINDOW(MAX_WINDOW)) u_dpath (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_data_i), .ctl_i(ctl), .sts_o(sts), .out_o(out_data_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_nontrans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.channel_out > 3'd3) |-> !out_data_o.transient)
    else $error("transient on high channel");

endmodule

/* dv/testbench.sv */
// Testbench for adc_smoothing_transient_envelope: directed table, then random scan sequences.
// Depends on adcse_pkg and the block; checks every result against an in-file predictor.
module testbench;
  import adcse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  adc_smoothing_transient_envelope dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  logic [1:0] atten_q;
  logic [10:0] thresh_q;
  logic [5:0] win_q [4];
  logic [9:0] ring_q [8][4];
  logic [1:0] slot_q;
  logic [9:0] store_q [4][32];
  int unsigned sum_q [4];
  int unsigned idx_q [4];
  logic [9:0] env_q [4];

  out_item_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int transients = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet = 0;

  function automatic void predictor_reset();
    atten_q = '0;
    thresh_q = 11'd160;
    for (int b = 0; b < 4; b++) begin
      win_q[b] = 6'd32;
      sum_q[b] = 0;
      idx_q[b] = 0;
      env_q[b] = '0;
      for (int k = 0; k < 32; k++) store_q[b][k] = '0;
    end
    for (int c = 0; c < 8; c++) for (int k = 0; k < 4; k++) ring_q[c][k] = '0;
    slot_q = '0;
  endfunction

  function automatic void band_accumulate(int b, logic [9:0] s);
    int unsigned w;
    int unsigned i;
    int unsigned e;
    w = (win_q[b] == 0) ? 1 : (win_q[b] > 32 ? 32 : win_q[b]);
    i = (idx_q[b] >= 32) ? 0 : idx_q[b];
    sum_q[b] = sum_q[b] - store_q[b][i] + s;
    store_q[b][i] = s;
    e = sum_q[b] / w;
    env_q[b] = (e > 1023) ? 10'd1023 : e[9:0];
    i++;
    idx_q[b] = (i >= w) ? 0 : i;
  endfunction

  function automatic out_item_t smooth_sample(in_item_t it);
    out_item_t r;
    logic [1:0] p;
    int unsigned a;
    int d;
    int unsigned g;
    int unsigned mag;
    r = '0;
    r.channel_out = it.channel;
    p = slot_q;
    ring_q[it.channel][p] = it.sample;
    a = (ring_q[it.channel][0] + ring_q[it.channel][1] + ring_q[it.channel][2]
         + ring_q[it.channel][3]) >> 2;
    g = (atten_q == 0) ? GAIN_MODE0 : (atten_q == 1) ? GAIN_MODE1 : GAIN_MODE2;
    r.average = 10'(a);
    r.scaled = 11'((a * g) >> 10);
    if (it.channel < 4) begin
      d = int'(ring_q[it.channel][p]) - int'(ring_q[it.channel][p - 2'd1])
          + int'(ring_q[it.channel][p - 2'd2]) - int'(ring_q[it.channel][p - 2'd3]);
      mag = (d < 0) ? -d : d;
      r.band_pair = it.channel[0];
      if (mag > thresh_q) begin
        r.transient = 1'b1;
        band_accumulate(2 * r.band_pair, it.sample);
        band_accumulate(2 * r.band_pair + 1, it.sample);
      end
      r.envelope_first = env_q[2 * r.band_pair];
      r.envelope_second = env_q[2 * r.band_pair + 1];
      r.deviation = d[11:0];
    end
    if (it.channel == 3'd7) slot_q = slot_q + 2'd1;
    return r;
  endfunction

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %p", $time, out_data_o);
          errors++;
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          checked++;
          if (e.transient) transients++;
          if (e !== out_data_o) begin
            $display("%0t mismatch expected %p actual %p", $time, e, out_data_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_sample(logic [2:0] ch, logic [9:0] s, bit has_exp = 0,
                             out_item_t exp_item = '0);
    in_item_t it;
    out_item_t r;
    it.channel = ch;
    it.sample = s;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = smooth_sample(it);
    if (has_exp && r !== exp_item) begin
      $display("%0t table mismatch expected %p actual %p", $time, exp_item, r);
      errors++;
    end
    expected_results.push_back(r);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ATTEN: atten_q = v[1:0];
      REG_THRESH: thresh_q = v;
      default: win_q[idx - REG_WIN0] = v[5:0];
    endcase
    @(posedge clk_i);
  endtask

  typedef struct {
    logic [2:0] ch;
    logic [9:0] s;
    bit has_exp;
    out_item_t exp_item;
  } row_t;

  task automatic scan_burst(int n);
    logic [9:0] base;
    for (int k = 0; k < n; k++) begin
      base = 10'($urandom_range(1023));
      for (int c = 0; c < 8; c++) begin
        if ($urandom_range(99) < 8) send_sample(3'($urandom_range(7)), 10'($urandom));
        else if ($urandom_range(1)) send_sample(3'(c), 10'($urandom));
        else send_sample(3'(c), base + 10'($urandom_range(64)) - 10'd32);
      end
    end
  endtask

  initial begin
    row_t rows[$];
    out_item_t x;
    predictor_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sample after reset: ring holds only it
    x = '0; x.average = 10'd255; x.scaled = 11'd509; x.deviation = 12'sd1023;
    x.transient = 1'b1; x.envelope_first = 10'd31; x.envelope_second = 10'd31;
    rows.push_back('{3'd0, 10'd1023, 1, x});
    x = '0; x.channel_out = 3'd1; x.band_pair = 1'b1;
    rows.push_back('{3'd1, 10'd0, 1, x});
    x = '0; x.channel_out = 3'd5; x.average = 10'd255; x.scaled = 11'd509;
    rows.push_back('{3'd5, 10'd1023, 1, x});
    for (int c = 0; c < 8; c++) rows.push_back('{3'(c), 10'(c * 146), 0, '0});
    for (int c = 0; c < 8; c++) rows.push_back('{3'(c), 10'd1023 - 10'(c * 3), 0, '0});
    rows.push_back('{3'd2, 10'd512, 0, '0});
    rows.push_back('{3'd7, 10'd1, 0, '0});
    rows.push_back('{3'd3, 10'd682, 0, '0});
    foreach (rows[i]) send_sample(rows[i].ch, rows[i].s, rows[i].has_exp, rows[i].exp_item);
    drain();

    // mode three, zero threshold, small / zero / oversized / shrinking windows
    write_reg(REG_ATTEN, 11'd3);
    write_reg(REG_THRESH, 11'd0);
    write_reg(REG_WIN0, 11'd1);
    write_reg(REG_WIN1, 11'd0);
    write_reg(REG_WIN2, 11'd63);
    write_reg(REG_WIN3, 11'd5);
    send_idle = 32; recv_idle = 54;
    scan_burst(30);
    drain();

    write_reg(REG_ATTEN, 11'd1);
    write_reg(REG_THRESH, 11'd2047);
    write_reg(REG_WIN0, 11'd32);
    write_reg(REG_WIN3, 11'd2);
    send_idle = 54; recv_idle = 32;
    scan_burst(25);
    drain();

    write_reg(REG_ATTEN, 11'd2);
    write_reg(REG_THRESH, 11'd40);
    write_reg(REG_WIN1, 11'd7);
    write_reg(REG_WIN2, 11'd3);
    send_idle = 0; recv_idle = 0;
    scan_burst(25);
    drain();

    write_reg(REG_ATTEN, 11'd0);
    write_reg(REG_THRESH, 11'd160);
    write_reg(REG_WIN0, 11'd17);
    scan_burst(30);
    drain();

    $display("covered %0d samples, %0d results checked, %0d transient", sent, checked,
             transients);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
